FILE: rtl/aesd_pkg.sv
// ----------------------------------------------------------------------------
// AES-128 decryption package
// Shared types, substitution tables and finite field helpers for the
// round cells and the key schedule.
// ----------------------------------------------------------------------------
`default_nettype none

package aesd_pkg;

   localparam int NUM_ROUNDS = 10;
   localparam int KEY_W      = 64;
   localparam int BLOCK_W    = 128;
   localparam int CSR_IDX_W  = 1;
   localparam int CNT_W      = 4;

   localparam logic [CSR_IDX_W-1:0] REG_KEY_HIGH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_LOW  = 1'b1;

   localparam logic [7:0] GF_POLY = 8'h1b;
   localparam logic [3:0] MUL_E   = 4'he;
   localparam logic [3:0] MUL_B   = 4'hb;
   localparam logic [3:0] MUL_D   = 4'hd;
   localparam logic [3:0] MUL_9   = 4'h9;

   typedef logic [BLOCK_W-1:0] block_type;
   typedef logic [NUM_ROUNDS:0][BLOCK_W-1:0] round_keys_type;

   localparam logic [7:0] FWD_SBOX [0:255] = '{
      8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
      8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
      8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
      8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
      8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
      8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
      8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
      8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
      8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
      8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
      8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
      8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
      8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
      8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
      8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
      8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
      8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
      8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
      8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
      8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
      8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
      8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
      8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
      8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
      8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
      8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
      8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
      8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
      8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
      8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
      8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
      8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
   };

   localparam logic [7:0] INV_SBOX [0:255] = '{
      8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
      8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
      8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
      8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
      8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
      8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
      8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
      8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
      8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
      8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
      8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
      8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
      8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
      8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
      8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
      8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
      8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
      8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
      8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
      8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
      8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
      8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
      8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
      8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
      8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
      8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
      8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
      8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
      8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
      8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
      8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
      8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
   };

   function automatic logic [7:0] gf_xtime(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] v, input logic [3:0] k);
      logic [7:0] acc;
      logic [7:0] p;
      acc = 8'h00;
      p   = v;
      for (int i = 0; i < 4; i++) begin
         if (k[i]) begin
            acc = acc ^ p;
         end
         p = gf_xtime(p);
      end
      return acc;
   endfunction

   function automatic logic [31:0] inv_mix_col(input logic [31:0] col);
      logic [7:0] a0, a1, a2, a3;
      a0 = col[31:24];
      a1 = col[23:16];
      a2 = col[15:8];
      a3 = col[7:0];
      return {gf_mul(a0, MUL_E) ^ gf_mul(a1, MUL_B) ^ gf_mul(a2, MUL_D) ^ gf_mul(a3, MUL_9),
              gf_mul(a0, MUL_9) ^ gf_mul(a1, MUL_E) ^ gf_mul(a2, MUL_B) ^ gf_mul(a3, MUL_D),
              gf_mul(a0, MUL_D) ^ gf_mul(a1, MUL_9) ^ gf_mul(a2, MUL_E) ^ gf_mul(a3, MUL_B),
              gf_mul(a0, MUL_B) ^ gf_mul(a1, MUL_D) ^ gf_mul(a2, MUL_9) ^ gf_mul(a3, MUL_E)};
   endfunction

   function automatic logic [7:0] round_const(input logic [CNT_W-1:0] rnd);
      logic [7:0] rc;
      case (rnd)
         4'd1:    rc = 8'h01;
         4'd2:    rc = 8'h02;
         4'd3:    rc = 8'h04;
         4'd4:    rc = 8'h08;
         4'd5:    rc = 8'h10;
         4'd6:    rc = 8'h20;
         4'd7:    rc = 8'h40;
         4'd8:    rc = 8'h80;
         4'd9:    rc = 8'h1b;
         4'd10:   rc = 8'h36;
         default: rc = 8'h00;
      endcase
      return rc;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/aes128_block_decrypt.sv
// ----------------------------------------------------------------------------
// AES-128 block decryption
// An accepted item passes through the input key-addition register and then
// the ten chained round cells; throughput is one item per cycle while
// rsp_tready stays high and the key schedule is idle. After reset, and after
// every key write, the key schedule runs with req_tready low; the reset key is all zeros.
// ----------------------------------------------------------------------------
`default_nettype none

module aes128_block_decrypt (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output      logic                             req_tready,
   input  wire logic [127:0]                     req_tdata,  // cipher_low, cipher_high
   output      logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   output      logic [127:0]                     rsp_tdata,  // plain_low, plain_high
   input  wire logic                             csr_we,
   input  wire logic [aesd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [aesd_pkg::KEY_W-1:0]       csr_wdata
);

   logic                       key_busy;
   aesd_pkg::round_keys_type   round_keys;
   logic                       s0_valid_ff;
   aesd_pkg::block_type        s0_data_ff;
   logic                       s0_ready;
   logic                       req_accept;
   logic                       cell_valid [aesd_pkg::NUM_ROUNDS];
   logic                       cell_ready [aesd_pkg::NUM_ROUNDS];
   aesd_pkg::block_type        cell_data  [aesd_pkg::NUM_ROUNDS];

   aesd_key_expand u_key_expand (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .busy       (key_busy),
      .round_keys (round_keys)
   );

   assign s0_ready   = !s0_valid_ff || cell_ready[0];
   assign req_tready = s0_ready && !key_busy;
   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (s0_ready) begin
         s0_valid_ff <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_ready) begin
         s0_data_ff <= {req_tdata[63:0], req_tdata[127:64]} ^
                       round_keys[aesd_pkg::NUM_ROUNDS];
      end
   end

   for (genvar k = 0; k < aesd_pkg::NUM_ROUNDS; k++) begin : g_cell
      logic                  prev_valid;
      aesd_pkg::block_type   prev_data;
      logic                  next_ready;

      if (k == 0) begin : g_first
         assign prev_valid = s0_valid_ff;
         assign prev_data  = s0_data_ff;
      end else begin : g_chain
         assign prev_valid = cell_valid[k - 1];
         assign prev_data  = cell_data[k - 1];
      end

      if (k == aesd_pkg::NUM_ROUNDS - 1) begin : g_last
         assign next_ready = rsp_tready;
      end else begin : g_mid
         assign next_ready = cell_ready[k + 1];
      end

      aesd_round_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .in_valid   (prev_valid),
         .in_data    (prev_data),
         .round_key  (round_keys[aesd_pkg::NUM_ROUNDS - 1 - k]),
         .skip_mix   (k == aesd_pkg::NUM_ROUNDS - 1),
         .down_ready (next_ready),
         .up_ready   (cell_ready[k]),
         .out_valid  (cell_valid[k]),
         .out_data   (cell_data[k])
      );
   end

   assign rsp_tvalid = cell_valid[aesd_pkg::NUM_ROUNDS - 1];
   assign rsp_tdata  = {cell_data[aesd_pkg::NUM_ROUNDS - 1][63:0],
                        cell_data[aesd_pkg::NUM_ROUNDS - 1][127:64]};

endmodule

`default_nettype wire

FILE: rtl/aesd_key_expand.sv
// ----------------------------------------------------------------------------
// AES-128 key schedule
// Holds the two key registers and, after reset and after every key write,
// expands it into eleven round keys, one per cycle, restarting on a write.
// ----------------------------------------------------------------------------
`default_nettype none

module aesd_key_expand (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [aesd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [aesd_pkg::KEY_W-1:0]       csr_wdata,
   output      logic                             busy,
   output      aesd_pkg::round_keys_type         round_keys
);

   logic [aesd_pkg::KEY_W-1:0]   key_high_ff;
   logic [aesd_pkg::KEY_W-1:0]   key_low_ff;
   logic                         busy_ff;
   logic [aesd_pkg::CNT_W-1:0]   cnt_ff;
   aesd_pkg::block_type          cur_ff;
   aesd_pkg::block_type          next_key_in;
   aesd_pkg::round_keys_type     rk_ff;

   always_comb begin
      logic [31:0] t;
      logic [31:0] w0, w1, w2, w3;
      w3 = cur_ff[31:0];
      t  = {aesd_pkg::FWD_SBOX[w3[23:16]], aesd_pkg::FWD_SBOX[w3[15:8]],
            aesd_pkg::FWD_SBOX[w3[7:0]],   aesd_pkg::FWD_SBOX[w3[31:24]]};
      t  = t ^ {aesd_pkg::round_const(cnt_ff), 24'h000000};
      w0 = cur_ff[127:96] ^ t;
      w1 = cur_ff[95:64] ^ w0;
      w2 = cur_ff[63:32] ^ w1;
      w3 = w3 ^ w2;
      next_key_in = {w0, w1, w2, w3};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
         busy_ff     <= 1'b1;
         cnt_ff      <= '0;
      end else if (csr_we) begin
         case (csr_index)
            aesd_pkg::REG_KEY_HIGH: key_high_ff <= csr_wdata;
            aesd_pkg::REG_KEY_LOW:  key_low_ff  <= csr_wdata;
            default: ;
         endcase
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == aesd_pkg::CNT_W'(aesd_pkg::NUM_ROUNDS)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!reset && !csr_we && busy_ff) begin
         if (cnt_ff == '0) begin
            rk_ff[0] <= {key_high_ff, key_low_ff};
            cur_ff   <= {key_high_ff, key_low_ff};
         end else begin
            rk_ff[cnt_ff] <= next_key_in;
            cur_ff        <= next_key_in;
         end
      end
   end

   assign busy       = busy_ff;
   assign round_keys = rk_ff;

endmodule

`default_nettype wire

FILE: rtl/aesd_round_cell.sv
// ----------------------------------------------------------------------------
// AES-128 inverse round cell
// One stage of the decryption chain: inverse shift rows, inverse
// substitution, round key addition and, unless disabled, inverse mix columns.
// ----------------------------------------------------------------------------
`default_nettype none

module aesd_round_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   input  wire aesd_pkg::block_type   in_data,
   input  wire aesd_pkg::block_type   round_key,
   input  wire logic                  skip_mix,
   input  wire logic                  down_ready,
   output      logic                  up_ready,
   output      logic                  out_valid,
   output      aesd_pkg::block_type   out_data
);

   logic                  valid_ff;
   aesd_pkg::block_type   data_ff;
   aesd_pkg::block_type   data_in;

   always_comb begin
      aesd_pkg::block_type sub;
      aesd_pkg::block_type keyed;
      aesd_pkg::block_type mixed;
      int src;
      for (int i = 0; i < 16; i++) begin
         src = 4 * (((i / 4) - (i % 4)) & 3) + (i % 4);
         sub[127 - 8 * i -: 8] = aesd_pkg::INV_SBOX[in_data[127 - 8 * src -: 8]];
      end
      keyed = sub ^ round_key;
      for (int c = 0; c < 4; c++) begin
         mixed[127 - 32 * c -: 32] = aesd_pkg::inv_mix_col(keyed[127 - 32 * c -: 32]);
      end
      data_in = skip_mix ? keyed : mixed;
   end

   assign up_ready = !valid_ff || down_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-128 block decryption testbench
// Drives ciphertext items into the decryptor and checks every plaintext item
// against a key schedule and inverse cipher computed here. The S-boxes are
// derived from field inversion and the affine map at time zero. A short
// table of directed items, with known FIPS-197 answers where they apply, is
// followed by random items under several keys and random idling on both
// sides.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

   localparam int STUCK_LIMIT  = 4000;
   localparam int PHASE_ITEMS  = 200;
   localparam int LONG_HOLD    = 300;
   localparam int DRAIN_CYCLES = 20;

   typedef enum logic {ROW_WRITE, ROW_BLOCK} row_kind_type;

   typedef struct packed {
      row_kind_type                        kind;
      logic [aesd_pkg::CSR_IDX_W-1:0]      index;
      logic [63:0]                         w0;
      logic [63:0]                         w1;
      logic                                checked;
      logic [63:0]                         e0;
      logic [63:0]                         e1;
   } vector_row_type;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [127:0]                    req_tdata  = '0;  // cipher_low, cipher_high
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [127:0]                    rsp_tdata;        // plain_low, plain_high
   logic                            csr_we     = 1'b0;
   logic [aesd_pkg::CSR_IDX_W-1:0]  csr_index  = '0;
   logic [aesd_pkg::KEY_W-1:0]      csr_wdata  = '0;

   logic [7:0]    fwd_sub [0:255];
   logic [7:0]    inv_sub [0:255];
   logic [31:0]   sched_words [0:43];
   logic [63:0]   key_high_q;
   logic [63:0]   key_low_q;

   logic [127:0]     plain_fifo [$];
   vector_row_type   vectors [$];

   int unsigned   errors       = 0;
   int unsigned   stuck_cycles = 0;
   int unsigned   gap_pct      = 0;
   int unsigned   stall_pct    = 0;
   int unsigned   stall_left   = 0;
   int unsigned   hold_left    = 0;
   bit            want_hold    = 1'b0;
   bit            hold_done    = 1'b0;

   aes128_block_decrypt DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic [7:0] gf_product(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      logic [7:0] p;
      acc = 8'h00;
      p   = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) begin
            acc = acc ^ p;
         end
         p = {p[6:0], 1'b0} ^ (p[7] ? 8'h1b : 8'h00);
      end
      return acc;
   endfunction

   function automatic logic [7:0] gf_inverse(input logic [7:0] x);
      logic [7:0] r;
      r = x;
      for (int k = 0; k < 253; k++) begin
         r = gf_product(r, x);
      end
      return r;
   endfunction

   task automatic build_sboxes();
      logic [7:0]  b;
      logic [15:0] d;
      for (int x = 0; x < 256; x++) begin
         b = gf_inverse(x[7:0]);
         d = {b, b};
         b = b ^ d[14:7] ^ d[13:6] ^ d[12:5] ^ d[11:4] ^ 8'h63;
         fwd_sub[x] = b;
         inv_sub[b] = x[7:0];
      end
   endtask

   task automatic expand_round_keys();
      logic [31:0] t;
      logic [7:0]  rcon;
      rcon = 8'h01;
      sched_words[0] = key_high_q[63:32];
      sched_words[1] = key_high_q[31:0];
      sched_words[2] = key_low_q[63:32];
      sched_words[3] = key_low_q[31:0];
      for (int w = 4; w < 44; w++) begin
         t = sched_words[w-1];
         if (w % 4 == 0) begin
            t = {fwd_sub[t[23:16]], fwd_sub[t[15:8]], fwd_sub[t[7:0]], fwd_sub[t[31:24]]}
                ^ {rcon, 24'h0};
            rcon = gf_product(rcon, 8'h02);
         end
         sched_words[w] = sched_words[w-4] ^ t;
      end
   endtask

   function automatic logic [127:0] round_key(input int rnd);
      return {sched_words[4*rnd], sched_words[4*rnd+1],
              sched_words[4*rnd+2], sched_words[4*rnd+3]};
   endfunction

   function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
      logic [127:0] t;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[8*(15 - (4*((c + r) % 4) + r)) +: 8] = inv_sub[s[8*(15 - (4*c + r)) +: 8]];
         end
      end
      return t;
   endfunction

   function automatic logic [127:0] inv_mix(input logic [127:0] s);
      logic [31:0]  col;
      logic [127:0] t;
      for (int c = 0; c < 4; c++) begin
         col = s[127 - 32*c -: 32];
         t[127 - 32*c -: 32] = {
            gf_product(col[31:24], 8'h0e) ^ gf_product(col[23:16], 8'h0b) ^
            gf_product(col[15:8], 8'h0d) ^ gf_product(col[7:0], 8'h09),
            gf_product(col[31:24], 8'h09) ^ gf_product(col[23:16], 8'h0e) ^
            gf_product(col[15:8], 8'h0b) ^ gf_product(col[7:0], 8'h0d),
            gf_product(col[31:24], 8'h0d) ^ gf_product(col[23:16], 8'h09) ^
            gf_product(col[15:8], 8'h0e) ^ gf_product(col[7:0], 8'h0b),
            gf_product(col[31:24], 8'h0b) ^ gf_product(col[23:16], 8'h0d) ^
            gf_product(col[15:8], 8'h09) ^ gf_product(col[7:0], 8'h0e)};
      end
      return t;
   endfunction

   // The state holds byte 0 in the top bits, as the item fields do.
   function automatic logic [127:0] decrypt_block(input logic [63:0] hi, input logic [63:0] lo);
      logic [127:0] s;
      s = {hi, lo} ^ round_key(10);
      for (int rnd = 9; rnd >= 1; rnd--) begin
         s = inv_mix(inv_shift_sub(s) ^ round_key(rnd));
      end
      return inv_shift_sub(s) ^ round_key(0);
   endfunction

   function automatic logic [63:0] random_word();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 15))
         0: begin
            v = 64'h0;
         end
         1: begin
            v = '1;
         end
         default: begin
         end
      endcase
      return v;
   endfunction

   function automatic void add_write(input logic [aesd_pkg::CSR_IDX_W-1:0] idx,
                                     input logic [63:0] value);
      vector_row_type row;
      row         = '0;
      row.kind    = ROW_WRITE;
      row.index   = idx;
      row.w0      = value;
      vectors.push_back(row);
   endfunction

   function automatic void add_block(input logic [63:0] hi, input logic [63:0] lo,
                                     input logic checked, input logic [63:0] ehi,
                                     input logic [63:0] elo);
      vector_row_type row;
      row         = '0;
      row.kind    = ROW_BLOCK;
      row.w0      = hi;
      row.w1      = lo;
      row.checked = checked;
      row.e0      = ehi;
      row.e1      = elo;
      vectors.push_back(row);
   endfunction

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (plain_fifo.size() != 0) @(posedge clock);
   endtask

   task automatic maybe_gap();
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   task automatic write_key(input logic [aesd_pkg::CSR_IDX_W-1:0] idx, input logic [63:0] value);
      wait_drained();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == aesd_pkg::REG_KEY_HIGH) begin
         key_high_q = value;
      end else begin
         key_low_q = value;
      end
      expand_round_keys();
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_block(input logic [63:0] hi, input logic [63:0] lo, input logic checked,
                             input logic [63:0] ehi, input logic [63:0] elo);
      logic [127:0] plain;
      req_tdata  <= {lo, hi};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      plain = decrypt_block(hi, lo);
      if (checked) begin
         plain_fifo.push_back({elo, ehi});
      end else begin
         plain_fifo.push_back({plain[63:0], plain[127:64]});
      end
   endtask

   always @(posedge clock) begin
      if (want_hold && !hold_done) begin
         hold_done = 1'b1;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left  = hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
         stall_left = $urandom_range(1, 11) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      logic [127:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (plain_fifo.size() == 0) begin
            $display("%0t: result with nothing expected, actual %h", $time, rsp_tdata);
            errors = errors + 1;
         end else begin
            want = plain_fifo.pop_front();
            if (rsp_tdata[63:0] !== want[63:0]) begin
               $display("%0t: plain_high mismatch, expected %h, actual %h",
                        $time, want[63:0], rsp_tdata[63:0]);
               errors = errors + 1;
            end
            if (rsp_tdata[127:64] !== want[127:64]) begin
               $display("%0t: plain_low mismatch, expected %h, actual %h",
                        $time, want[127:64], rsp_tdata[127:64]);
               errors = errors + 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles = stuck_cycles + 1;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      vector_row_type row;

      key_high_q = 64'h0;
      key_low_q  = 64'h0;
      build_sboxes();
      expand_round_keys();

      add_block(64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e, 1'b1, 64'h0, 64'h0);
      add_block(64'h0, 64'h0, 1'b0, 64'h0, 64'h0);
      add_block('1, '1, 1'b0, 64'h0, 64'h0);
      add_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0, 64'h0, 64'h0);
      add_write(aesd_pkg::REG_KEY_HIGH, 64'h0001020304050607);
      add_write(aesd_pkg::REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
      add_block(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b1,
                64'h0011223344556677, 64'h8899aabbccddeeff);
      add_write(aesd_pkg::REG_KEY_HIGH, 64'h2b7e151628aed2a6);
      add_write(aesd_pkg::REG_KEY_LOW, 64'habf7158809cf4f3c);
      add_block(64'h3925841d02dc09fb, 64'hdc118597196a0b32, 1'b1,
                64'h3243f6a8885a308d, 64'h313198a2e0370734);
      add_block('1, 64'h0, 1'b0, 64'h0, 64'h0);
      add_block(64'h0, '1, 1'b0, 64'h0, 64'h0);
      add_write(aesd_pkg::REG_KEY_HIGH, '1);
      add_write(aesd_pkg::REG_KEY_LOW, '1);
      add_block(64'h0, 64'h0, 1'b0, 64'h0, 64'h0);
      add_block('1, '1, 1'b0, 64'h0, 64'h0);
      add_write(aesd_pkg::REG_KEY_LOW, 64'h0);
      add_block(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0, 64'h0, 64'h0);
      add_write(aesd_pkg::REG_KEY_HIGH, 64'h0);
      add_block(64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e, 1'b1, 64'h0, 64'h0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      gap_pct   = 20;
      stall_pct = 20;
      for (int n = 0; n < vectors.size(); n++) begin
         row = vectors[n];
         if (row.kind == ROW_WRITE) begin
            write_key(row.index, row.w0);
         end else begin
            maybe_gap();
            send_block(row.w0, row.w1, row.checked, row.e0, row.e1);
         end
      end

      for (int p = 0; p < 7; p++) begin
         case (p)
            0: begin
               gap_pct   = 0;
               stall_pct = 0;
            end
            1: begin
               write_key(aesd_pkg::REG_KEY_HIGH, 64'h0);
               write_key(aesd_pkg::REG_KEY_LOW, 64'h0);
               gap_pct   = 30;
               stall_pct = 30;
            end
            2: begin
               write_key(aesd_pkg::REG_KEY_HIGH, random_word());
               write_key(aesd_pkg::REG_KEY_LOW, random_word());
               gap_pct   = 10;
               stall_pct = 10;
            end
            3: begin
               write_key(aesd_pkg::REG_KEY_HIGH, '1);
               write_key(aesd_pkg::REG_KEY_LOW, '1);
               gap_pct   = 40;
               stall_pct = 5;
            end
            4: begin
               write_key(aesd_pkg::REG_KEY_LOW, random_word());
               gap_pct   = 5;
               stall_pct = 40;
            end
            5: begin
               write_key(aesd_pkg::REG_KEY_HIGH, random_word());
               gap_pct   = 20;
               stall_pct = 20;
            end
            default: begin
               write_key(aesd_pkg::REG_KEY_HIGH, random_word());
               write_key(aesd_pkg::REG_KEY_LOW, random_word());
               gap_pct   = 0;
               stall_pct = 0;
            end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 2 && n == 40) begin
               want_hold = 1'b1;
            end
            if (p == 3 && n == 100) begin
               wait_drained();
            end else begin
               maybe_gap();
            end
            send_block(random_word(), random_word(), 1'b0, 64'h0, 64'h0);
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: aes128_block_decrypt.f
rtl/aesd_pkg.sv
rtl/aesd_key_expand.sv
rtl/aesd_round_cell.sv
rtl/aes128_block_decrypt.sv
tb/sv/testbench.sv
